/* rtl/ipv6_address_shortener_macros.svh */
// Assertion macros shared by the shortener RTL.
// Each macro takes a label, the clock, the active-low reset, two
// expressions and a message string.
`ifndef IPV6_ADDRESS_SHORTENER_MACROS_SVH
`define IPV6_ADDRESS_SHORTENER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPV6AS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IPV6AS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ipv6as_pkg.sv */
`default_nettype none

package ipv6as_pkg;

	localparam int GROUPS      = 8;
	localparam int GROUP_W     = 16;
	localparam int GIDX_W      = 3;
	localparam int CHAR_W      = 7;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CHAR_W-1:0] CHAR_COLON  = 7'h3A;
	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;

	typedef struct packed {
		logic [63:0] address_high;
		logic [63:0] address_low;
	} addr_t;

	typedef struct packed {
		logic [CHAR_W-1:0] text_char;
		logic              last_char;
	} text_t;

	// One classified address: its groups and the zero run chosen for "::".
	typedef struct packed {
		logic [GROUPS-1:0][GROUP_W-1:0] grp;
		logic                           compress;
		logic [GIDX_W-1:0]              run_start;
		logic [GIDX_W-1:0]              run_end;
	} job_t;

	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + {3'b000, d};
		end else begin
			c = CHAR_LOWER_A + {3'b000, d - 4'd10};
		end
		return c;
	endfunction

	// Number of hex digits written for a group; a zero group still takes one.
	function automatic logic [2:0] sig_digits(input logic [GROUP_W-1:0] v);
		logic [2:0] n;
		if (v[15:12] != 4'd0) begin
			n = 3'd4;
		end else if (v[11:8] != 4'd0) begin
			n = 3'd3;
		end else if (v[7:4] != 4'd0) begin
			n = 3'd2;
		end else begin
			n = 3'd1;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

/* rtl/ipv6as_stream_if.sv */
`default_nettype none

interface ipv6as_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/ipv6as_front.sv */
`default_nettype none
`include "ipv6_address_shortener_macros.svh"

module ipv6as_front (
	input  logic              clk,
	input  logic              arst_n,
	ipv6as_stream_if.sink     addr,
	output logic              push,
	output ipv6as_pkg::job_t  push_job,
	input  logic              full
);
	import ipv6as_pkg::*;

	logic                           vld_s1;
	addr_t                          addr_s1;
	logic [GROUPS-1:0][GROUP_W-1:0] grp;
	logic [GROUPS:0]                zx;
	logic [3:0]                     cnt;
	logic [3:0]                     s4;
	logic [4:0]                     score;
	logic [4:0]                     best_score;
	logic [GIDX_W-1:0]              best_s;
	logic [GIDX_W-1:0]              best_e;

	assign addr.ready = !vld_s1 || !full;
	assign push       = vld_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (addr.ready) begin
			vld_s1 <= addr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (addr.valid && addr.ready) begin
			addr_s1 <= addr.payload;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			grp[i]     = addr_s1.address_high[48 - 16 * i +: GROUP_W];
			grp[i + 4] = addr_s1.address_low[48 - 16 * i +: GROUP_W];
		end
	end

	assign push_job.grp = grp;

	always_comb begin
		for (int i = 0; i < GROUPS; i++) begin
			zx[i] = (grp[i] == '0);
		end
		zx[GROUPS] = 1'b0;
	end

	// Walk the maximal zero runs. A run of k groups saves 2k-1 characters,
	// one less for each end of the address it touches. Among equal savings
	// the later run gives the smaller text, hence the >= compare.
	always_comb begin
		cnt        = 4'd0;
		s4         = 4'd0;
		score      = 5'd0;
		best_score = 5'd0;
		best_s     = '0;
		best_e     = '0;
		for (int i = 0; i < GROUPS; i++) begin
			cnt = zx[i] ? cnt + 4'd1 : 4'd0;
			if (zx[i] && !zx[i + 1] && cnt >= 4'd2) begin
				s4    = 4'(i + 1) - cnt;
				score = {cnt, 1'b0} - 5'd1 - {4'd0, s4 == 4'd0} - {4'd0, i == GROUPS - 1};
				if (score >= best_score) begin
					best_score = score;
					best_s     = s4[GIDX_W-1:0];
					best_e     = GIDX_W'(i);
				end
			end
		end
	end

	assign push_job.compress  = (best_score != 5'd0);
	assign push_job.run_start = best_s;
	assign push_job.run_end   = best_e;

	`IPV6AS_ASSERT_IMPLIES(a_run_is_zero, clk, arst_n, push && push_job.compress, (push_job.run_end > push_job.run_start) && zx[push_job.run_start] && zx[push_job.run_end], "chosen run is not a zero run of two or more groups")
	`IPV6AS_ASSERT_NEXT(a_s1_holds, clk, arst_n, vld_s1 && full, vld_s1 && $stable(addr_s1), "stalled address left the front stage")

endmodule

`default_nettype wire

/* rtl/ipv6as_queue.sv */
`default_nettype none

module ipv6as_queue #(
	parameter int Depth = ipv6as_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ipv6as_pkg::job_t  push_job,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output ipv6as_pkg::job_t  head_job
);
	import ipv6as_pkg::*;

	localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	job_t            mem_q [Depth];
	logic [IdxW-1:0] wr_ptr_q;
	logic [IdxW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full       = (count_q == CntW'(Depth));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/ipv6as_back.sv */
`default_nettype none
`include "ipv6_address_shortener_macros.svh"

module ipv6as_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  ipv6as_pkg::job_t  head_job,
	output logic              pop,
	ipv6as_stream_if.source   text
);
	import ipv6as_pkg::*;

	logic [GIDX_W-1:0]  grp_q;
	logic [2:0]         pos_q;
	logic               tvalid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	logic [GROUP_W-1:0] v;
	logic [2:0]         nd;
	logic               run_here;
	logic               has_sep;
	logic [2:0]         n_chars;
	logic [3:0]         next_grp;
	logic               last_in_grp;
	logic               last_item;
	logic [2:0]         d_idx;
	logic [CHAR_W-1:0]  ch;
	logic               advance;

	assign v        = head_job.grp[grp_q];
	assign nd       = sig_digits(v);
	assign run_here = head_job.compress && (grp_q == head_job.run_start);
	// No separator on the first group or right after the "::".
	assign has_sep  = (grp_q != '0) &&
		!(head_job.compress && ({1'b0, grp_q} == {1'b0, head_job.run_end} + 4'd1));
	assign n_chars  = run_here ? 3'd2 : nd + {2'b00, has_sep};
	assign next_grp = run_here ? {1'b0, head_job.run_end} + 4'd1 : {1'b0, grp_q} + 4'd1;
	assign last_in_grp = (pos_q == n_chars - 3'd1);
	assign last_item   = last_in_grp && (next_grp == 4'(GROUPS));
	assign d_idx    = nd - 3'd1 - (pos_q - {2'b00, has_sep});

	always_comb begin
		if (run_here || (has_sep && pos_q == 3'd0)) begin
			ch = CHAR_COLON;
		end else begin
			ch = hex_char(v[{d_idx[1:0], 2'b00} +: 4]);
		end
	end

	assign advance = head_valid && (!tvalid_q || text.ready);
	assign pop     = advance && last_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q    <= '0;
			pos_q    <= '0;
			tvalid_q <= 1'b0;
		end else begin
			if (advance) begin
				tvalid_q <= 1'b1;
				if (last_in_grp) begin
					pos_q <= '0;
					grp_q <= last_item ? '0 : next_grp[GIDX_W-1:0];
				end else begin
					pos_q <= pos_q + 3'd1;
				end
			end else if (text.ready) begin
				tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			char_q <= ch;
			last_q <= last_item;
		end
	end

	assign text.valid             = tvalid_q;
	assign text.payload.text_char = char_q;
	assign text.payload.last_char = last_q;

	`IPV6AS_ASSERT_IMPLIES(a_pos_in_group, clk, arst_n, head_valid, pos_q < n_chars, "character position beyond the current group")
	`IPV6AS_ASSERT_NEXT(a_restart_after_last, clk, arst_n, advance && last_item, (grp_q == '0) && (pos_q == '0), "sequencer did not restart after the final character")

endmodule

`default_nettype wire

/* rtl/ipv6_address_shortener.sv */
// Channel | Dir | Payload                          | Transfer
// addr    | in  | address_high[64], address_low[64] | valid && ready
// text    | out | text_char[7], last_char[1]        | valid && ready
//
// One character leaves per cycle while the text sink is ready; the text of
// an address has 2 to 39 characters, sent over the one-character output port.
// The address passes the front register, the queue and the output register.
// Reset is asynchronous and active low; it empties the front stage, the queue
// and the output register.
// Either side may stall on its own: the queue takes addresses while the
// output waits, until full, and the output keeps draining while input is idle.
`default_nettype none

module ipv6_address_shortener #(
	parameter int QueueDepth = ipv6as_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	ipv6as_stream_if.sink   addr,
	ipv6as_stream_if.source text
);
	import ipv6as_pkg::*;

	// Front stage to queue. The front registers the address, splits it into
	// eight groups and picks the zero run to compress, if any.
	logic push;
	job_t push_job;
	logic full;

	// Queue to back end. The back end walks the chosen text one character
	// per cycle unless stalled, and retires the entry on the final character.
	logic head_valid;
	job_t head_job;
	logic pop;

	ipv6as_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.addr     (addr),
		.push     (push),
		.push_job (push_job),
		.full     (full)
	);

	// Short queue that decouples classification from character output.
	ipv6as_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	ipv6as_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.text       (text)
	);

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	import ipv6as_pkg::*;

	// Longest text an address can produce: eight four-digit groups and seven colons.
	localparam int TEXT_MAX = 39;
	// Generous bound: about 380 addresses of up to 39 characters each, with
	// the sink stalling about a fifth of the time, fits in a small part of this.
	localparam int CYCLE_LIMIT = 400000;
	// Number of random addresses in each of the two random phases.
	localparam int SCATTERED_COUNT = 240;
	localparam int STEADY_COUNT = 120;

	logic clk;
	logic arst_n;
	int cycle_count;
	int mismatch_count;

	// While set, neither side of the block ever idles.
	bit steady;

	// Characters still owed by the block, oldest first.
	text_t expected_chars[$];

	ipv6as_stream_if #(.payload_t(addr_t)) addr_if ();
	ipv6as_stream_if #(.payload_t(text_t)) text_if ();

	ipv6_address_shortener dut (
		.clk(clk),
		.arst_n(arst_n),
		.addr(addr_if),
		.text(text_if)
	);

	initial begin
		clk = 1'b0;
	end

	always #2 clk = ~clk;

	// The run is cut off here if the block stops producing characters.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// The sink stalls at random except during the steady phase.
	always @(posedge clk) begin
		text_if.ready <= steady || ($urandom_range(99) >= 19);
	end

	// Each mismatch prints one line, up to a cap that keeps the log short,
	// and is always counted.
	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 50) begin
			$display("mismatch at cycle %0d: %s", cycle_count, what);
		end
	endtask

	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_LOWER_A + CHAR_W'(d - 4'd10);
		end
		return c;
	endfunction

	// Writes the text of the address with groups run_lo..run_hi folded into
	// "::". A negative run_lo writes the uncompressed form. Returns the length.
	function automatic int render_text(input logic [15:0] grp [GROUPS], input int run_lo,
			input int run_hi, output logic [CHAR_W-1:0] chars [TEXT_MAX]);
		int n;
		bit leading;
		bit in_run;
		bit after_run;
		logic [3:0] d;
		n = 0;
		foreach (chars[k]) begin
			chars[k] = '0;
		end
		for (int i = 0; i < GROUPS; i++) begin
			in_run = run_lo >= 0 && i >= run_lo && i <= run_hi;
			after_run = run_lo >= 0 && i - 1 >= run_lo && i - 1 <= run_hi;
			if (in_run) begin
				// The whole run becomes a double colon, which also serves as
				// the separator on both sides of it.
				if (i == run_lo) begin
					chars[n] = CHAR_COLON;
					chars[n + 1] = CHAR_COLON;
					n += 2;
				end
			end else begin
				if (i != 0 && !after_run) begin
					chars[n] = CHAR_COLON;
					n++;
				end
				if (grp[i] == 16'h0000) begin
					chars[n] = CHAR_ZERO;
					n++;
				end else begin
					// Leading zero digits of a group are dropped.
					leading = 1'b1;
					for (int k = 3; k >= 0; k--) begin
						d = grp[i][4 * k +: 4];
						if (!(leading && d == 4'd0)) begin
							leading = 1'b0;
							chars[n] = digit_char(d);
							n++;
						end
					end
				end
			end
		end
		return n;
	endfunction

	// Works out the shortest text of an address and queues its characters.
	// Every maximal run of two or more zero groups is tried as "::"; the
	// shortest form wins, and among equally short forms the smallest in ASCII.
	function automatic void predict_text(input addr_t a);
		logic [15:0] grp [GROUPS];
		logic [CHAR_W-1:0] best_chars [TEXT_MAX];
		logic [CHAR_W-1:0] trial [TEXT_MAX];
		int best_len;
		int n;
		int i;
		int j;
		bit smaller;
		bit decided;
		text_t e;
		for (int g = 0; g < 4; g++) begin
			grp[g] = a.address_high[63 - 16 * g -: 16];
			grp[g + 4] = a.address_low[63 - 16 * g -: 16];
		end
		best_len = render_text(grp, -1, -1, best_chars);
		i = 0;
		while (i < GROUPS) begin
			if (grp[i] == 16'h0000) begin
				j = i;
				while (j + 1 < GROUPS && grp[j + 1] == 16'h0000) begin
					j++;
				end
				if (j > i) begin
					n = render_text(grp, i, j, trial);
					smaller = 1'b0;
					decided = 1'b0;
					if (n == best_len) begin
						for (int k = 0; k < n; k++) begin
							if (!decided && trial[k] != best_chars[k]) begin
								smaller = trial[k] < best_chars[k];
								decided = 1'b1;
							end
						end
					end
					if (n < best_len || smaller) begin
						best_chars = trial;
						best_len = n;
					end
				end
				i = j + 1;
			end else begin
				i++;
			end
		end
		for (int k = 0; k < best_len; k++) begin
			e.text_char = best_chars[k];
			e.last_char = (k == best_len - 1);
			expected_chars.push_back(e);
		end
	endfunction

	// Every character transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		text_t got;
		text_t want;
		if (arst_n && text_if.valid && text_if.ready) begin
			got = text_if.payload;
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected character 0x%02h", got.text_char));
			end else begin
				want = expected_chars.pop_front();
				if (got.text_char !== want.text_char) begin
					report_mismatch($sformatf("text_char 0x%02h, expected 0x%02h",
						got.text_char, want.text_char));
				end
				if (got.last_char !== want.last_char) begin
					report_mismatch($sformatf("last_char %0b, expected %0b",
						got.last_char, want.last_char));
				end
			end
		end
	end

	// Offers one address and returns at the clock edge of its transfer.
	// Valid is never lowered at the end: the next call either idles or keeps
	// it high, so the signal gets only one assignment per time step.
	task automatic send_address(input logic [63:0] high, input logic [63:0] low);
		addr_t a;
		a.address_high = high;
		a.address_low = low;
		while (!steady && $urandom_range(99) < 19) begin
			addr_if.valid <= 1'b0;
			@(posedge clk);
		end
		addr_if.valid <= 1'b1;
		addr_if.payload <= a;
		do begin
			@(posedge clk);
		end while (!addr_if.ready);
		predict_text(a);
	endtask

	// Zero groups are common so that runs of every length and position show
	// up; nonzero groups come with one to four significant digits.
	function automatic logic [15:0] random_group();
		logic [15:0] v;
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				v = 16'h0000;
			end
			4: begin
				v = 16'hffff;
			end
			default: begin
				v = 16'($urandom_range(16'hffff));
				v = v >> (4 * $urandom_range(3));
			end
		endcase
		return v;
	endfunction

	task automatic send_random_address();
		logic [63:0] high;
		logic [63:0] low;
		if ($urandom_range(3) == 0) begin
			// Fully random halves make sure every address bit toggles.
			high = {$urandom, $urandom};
			low = {$urandom, $urandom};
		end else begin
			high = {random_group(), random_group(), random_group(), random_group()};
			low = {random_group(), random_group(), random_group(), random_group()};
		end
		send_address(high, low);
	endtask

	// Hand-picked addresses: the field extremes, runs at either end, single
	// zero groups, ties between equally short forms and every hex digit.
	task automatic test_special_addresses();
		send_address(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000);
		send_address(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
		send_address(64'h0000_0000_0000_0001, 64'h0002_0003_0004_0005);
		send_address(64'h0001_0002_0003_0004, 64'h0005_0000_0000_0000);
		send_address(64'h0001_0000_0002_0000, 64'h0003_0000_0004_0000);
		// Two runs of equal length inside the address.
		send_address(64'h0001_0000_0000_0002, 64'h0000_0000_0003_0004);
		// Equal runs at the start and at the end.
		send_address(64'h0000_0000_0001_0002, 64'h0003_0004_0000_0000);
		send_address(64'h0001_0000_0000_0002, 64'h0000_0000_0000_0003);
		send_address(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001);
		send_address(64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000);
		send_address(64'h0001_0010_0100_1000, 64'h000a_00b0_0c00_d000);
		send_address(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
		send_address(64'h0000_0000_0001_0000, 64'h0000_0001_0000_0000);
		send_address(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
		send_address(64'h0000_ffff_0000_ffff, 64'h0000_ffff_0000_ffff);
		send_address(64'hffff_0000_ffff_0000, 64'hffff_0000_0000_ffff);
		send_address(64'h0000_0000_ffff_ffff, 64'hffff_ffff_ffff_0000);
		send_address(64'h0000_0001_0000_0000, 64'h0001_0000_0000_0000);
		send_address(64'h000f_00f0_0f00_f000, 64'h0000_0000_0000_000a);
	endtask

	// Random addresses with both sides idling at random.
	task automatic test_scattered_traffic();
		repeat (SCATTERED_COUNT) begin
			send_random_address();
		end
	endtask

	// Random addresses back to back with neither side ever idling.
	task automatic test_steady_stream();
		steady = 1'b1;
		repeat (STEADY_COUNT) begin
			send_random_address();
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		steady = 1'b0;
		cycle_count = 0;
		mismatch_count = 0;
		addr_if.valid = 1'b0;
		addr_if.payload = '0;
		text_if.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_addresses();
		test_scattered_traffic();
		test_steady_stream();
		addr_if.valid <= 1'b0;

		// Drain, then give the pipeline a few cycles to show any stray output.
		while (expected_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
